>>> design/srr_pkg.sv
// srr_pkg: request and result types for the selective-repeat receiver.
// Used by selective_repeat_receiver; no dependencies.
package srr_pkg;

	// One arriving packet
	typedef struct packed {
		logic [31:0] seq;
		logic [63:0] payload;
		logic        corrupt;
	} in_req_t;

	// One result: acknowledgement or in-order delivery
	typedef struct packed {
		logic        kind;
		logic [31:0] out_seq;
		logic [63:0] out_data;
		logic        last;
		logic        done_res;
	} out_res_t;

	// Result kinds
	localparam logic KIND_ACK     = 1'b0;
	localparam logic KIND_DELIVER = 1'b1;

	// Register map (byte addresses)
	localparam logic [2:0] ADDR_TOTAL_PACKETS = 3'd0;

endpackage

>>> design/srr_cell.sv
// srr_cell: one slot of the receive window, holding a flag and a payload word.
// Shifts toward the window base on request; depends on nothing else.
module srr_cell #(
	parameter int DATA_BITS = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  logic [DATA_BITS-1:0] wr_data,
	input  logic                 shift_en,
	input  logic                 nxt_flag,
	input  logic [DATA_BITS-1:0] nxt_data,
	output logic                 flag,
	output logic [DATA_BITS-1:0] data
);

	logic                 flag_q;
	logic [DATA_BITS-1:0] data_q;

	// Hold flag: set on first write, take neighbor's on shift
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flag_q <= 1'b0;
		end else if (shift_en) begin
			flag_q <= nxt_flag;
		end else if (wr_en) begin
			flag_q <= 1'b1;
		end
	end

	// Hold data: keep the first copy of a packet, take neighbor's on shift
	always_ff @(posedge clk) begin
		if (shift_en) begin
			data_q <= nxt_data;
		end else if (wr_en && !flag_q) begin
			data_q <= wr_data;
		end
	end

	assign flag = flag_q;
	assign data = data_q;

endmodule

>>> design/selective_repeat_receiver.sv
// selective_repeat_receiver: top level of the selective-repeat ARQ receiver.
// Depends on srr_pkg (types, constants) and srr_cell (window slots).
//
// Usage:
//   in channel  (in_valid/in_ready/in_req): one arriving packet per request.
//   out channel (out_valid/out_ready/out_res): acknowledgements and in-order
//   deliveries, the acknowledgement first, last marking the final result of
//   a packet. Corrupt packets, packets outside both ranges and all packets
//   once the transfer is complete produce no result.
//   APB port: register 0 (byte address 0) is total_packets.
// Sequence: the acknowledgement is registered in the output register in the
//   cycle after the packet is accepted. A packet at the window base then
//   drains the run of held packets, one delivery per cycle while the output
//   is not stalled, and the row of WINDOW cells shifts one slot per delivery.
//   The next packet is accepted once the run is drained and the output
//   register is free or being emptied.
// Reset: window base, held flags and total_packets clear at once; no clearing
//   pass. With total_packets at 0 every packet is ignored.
// Stall: while a result waits and out_ready is low, the output register holds
//   it, the shift stops and in_ready stays low.
module selective_repeat_receiver #(
	parameter int WINDOW       = 16,
	parameter int PAYLOAD_BITS = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  srr_pkg::in_req_t   in_req,
	output logic               out_valid,
	input  logic               out_ready,
	output srr_pkg::out_res_t  out_res,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	localparam int IW = (WINDOW > 1) ? $clog2(WINDOW) : 1;

	typedef enum logic [1:0] {
		ST_IDLE  = 2'b01,
		ST_DELIV = 2'b10
	} state_t;

	state_t                  state_q;
	logic [31:0]             total_q;
	logic [31:0]             base_q;
	logic                    done_q;
	logic                    out_vld_q;
	srr_pkg::out_res_t       out_q;

	logic                    cell_flag [WINDOW];
	logic [PAYLOAD_BITS-1:0] cell_data [WINDOW];
	logic [WINDOW-1:0]       cell_wr;
	logic [WINDOW-1:0]       cell_have;
	logic [WINDOW-1:0]       cell_ok;
	logic [WINDOW-1:0]       cell_top;

	logic                    accept;
	logic                    slot_free;
	logic                    active;
	logic [31:0]             diff;
	logic                    in_win;
	logic [IW-1:0]           d_idx;
	logic [31:0]             low;
	logic                    in_back;
	logic [31:0]             k_left;
	logic [31:0]             top_off;
	logic                    base_wraps;
	logic                    done_calc;
	logic                    do_shift;
	logic                    deliv_last;
	logic [PAYLOAD_BITS-1:0] wr_payload;

	// APB: write total_packets, read it back
	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
		end else if (psel && penable && pwrite && paddr == srr_pkg::ADDR_TOTAL_PACKETS) begin
			total_q <= pwdata;
		end
	end
	assign prdata = (paddr == srr_pkg::ADDR_TOTAL_PACKETS) ? total_q : '0;

	// Handshake
	assign slot_free = !out_vld_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE) && slot_free;
	assign accept    = in_valid && in_ready;
	assign active    = !in_req.corrupt && (base_q < total_q);

	// Classify the packet against the window
	assign diff    = in_req.seq - base_q;
	assign in_win  = (in_req.seq >= base_q) && (diff < 32'(WINDOW));
	assign d_idx   = diff[IW-1:0];
	assign low     = (base_q >= 32'(WINDOW)) ? (base_q - 32'(WINDOW)) : '0;
	assign in_back = (in_req.seq >= low) && (in_req.seq < base_q);
	assign wr_payload = in_req.payload[PAYLOAD_BITS-1:0];

	// Transfer completes if the held run, with this packet, reaches total,
	// unless the run carries the base past the top of the sequence space
	assign k_left  = total_q - base_q;
	assign top_off = ~base_q;
	genvar gi;
	generate
		for (gi = 0; gi < WINDOW; gi++) begin : g_ok
			assign cell_wr[gi]   = accept && active && in_win && (d_idx == IW'(gi));
			assign cell_have[gi] = cell_flag[gi] || (in_win && d_idx == IW'(gi));
			assign cell_ok[gi]   = cell_have[gi] || (32'(gi) >= k_left);
			assign cell_top[gi]  = cell_have[gi] || (32'(gi) > top_off);
		end
	endgenerate
	assign base_wraps = (top_off < 32'(WINDOW)) && (&cell_top);
	assign done_calc  = (k_left <= 32'(WINDOW)) && (&cell_ok) && !base_wraps;

	// Delivery step: shift the row one slot toward the base
	assign do_shift   = (state_q == ST_DELIV) && slot_free;
	assign deliv_last = !cell_flag[1];

	// Row of window cells
	generate
		for (gi = 0; gi < WINDOW; gi++) begin : g_cell
			if (gi == WINDOW - 1) begin : g_top
				srr_cell #(.DATA_BITS(PAYLOAD_BITS)) u_cell (
					.clk      (clk),
					.arst_n   (arst_n),
					.wr_en    (cell_wr[gi]),
					.wr_data  (wr_payload),
					.shift_en (do_shift),
					.nxt_flag (1'b0),
					.nxt_data ('0),
					.flag     (cell_flag[gi]),
					.data     (cell_data[gi])
				);
			end else begin : g_mid
				srr_cell #(.DATA_BITS(PAYLOAD_BITS)) u_cell (
					.clk      (clk),
					.arst_n   (arst_n),
					.wr_en    (cell_wr[gi]),
					.wr_data  (wr_payload),
					.shift_en (do_shift),
					.nxt_flag (cell_flag[gi+1]),
					.nxt_data (cell_data[gi+1]),
					.flag     (cell_flag[gi]),
					.data     (cell_data[gi])
				);
			end
		end
	endgenerate

	// Sequencer: acknowledge, then drain the run at the base
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			base_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept && active && in_win && d_idx == '0) begin
						state_q <= ST_DELIV;
						done_q  <= done_calc;
					end
				end
				ST_DELIV: begin
					if (do_shift) begin
						base_q <= base_q + 32'd1;
						if (deliv_last) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if ((accept && active && (in_win || in_back)) || do_shift) begin
			out_vld_q <= 1'b1;
		end else if (out_ready) begin
			out_vld_q <= 1'b0;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (do_shift) begin
			out_q.kind     <= srr_pkg::KIND_DELIVER;
			out_q.out_seq  <= base_q;
			out_q.out_data <= 64'(cell_data[0]);
			out_q.last     <= deliv_last;
			out_q.done_res <= done_q;
		end else if (accept) begin
			out_q.kind     <= srr_pkg::KIND_ACK;
			out_q.out_seq  <= in_req.seq;
			out_q.out_data <= '0;
			out_q.last     <= !(in_win && d_idx == '0);
			out_q.done_res <= in_win && d_idx == '0 && done_calc;
		end
	end

	assign out_valid = out_vld_q;
	assign out_res   = out_q;

endmodule
